### rtl/sdlr_pkg.sv
`default_nettype none

package sdlr_pkg;

    // Shuffle table geometry.
    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int WARM_STEPS  = TABLE_DEPTH + 8;
    localparam int CNT_W       = $clog2(WARM_STEPS);

    // Value and shared multiplier widths.
    localparam int VAL_W     = 31;
    localparam int GEN_MUL_W = 16;
    localparam int MUL_B_W   = 18;
    localparam int PROD_W    = VAL_W + MUL_B_W;
    localparam int FOLD_W    = 8;

    // Both moduli sit just below 2^31, so a product folds as hi * (2^31 - m) + lo.
    localparam logic [VAL_W-1:0]     MOD_ONE  = 31'd2147483563;
    localparam logic [VAL_W-1:0]     MOD_TWO  = 31'd2147483399;
    localparam logic [GEN_MUL_W-1:0] MUL_ONE  = 16'd40014;
    localparam logic [GEN_MUL_W-1:0] MUL_TWO  = 16'd40692;
    localparam logic [FOLD_W-1:0]    FOLD_ONE = FOLD_W'((64'd1 << VAL_W) - 64'(MOD_ONE));
    localparam logic [FOLD_W-1:0]    FOLD_TWO = FOLD_W'((64'd1 << VAL_W) - 64'(MOD_TWO));
    localparam logic [VAL_W-1:0]     TOP_VAL  = MOD_ONE - 31'd1;
    localparam logic [VAL_W-1:0]     GEN_TWO_INIT = 31'd123456789;

    // Slot selection: last_out / SLOT_DIV through a reciprocal estimate that is
    // at most one below the true quotient.
    localparam longint unsigned SLOT_DIV_L  = 1 + (2147483563 - 1) / TABLE_DEPTH;
    localparam logic [VAL_W-1:0] SLOT_DIV   = VAL_W'(SLOT_DIV_L);
    localparam int               RECIP_SHIFT = 40;
    localparam logic [MUL_B_W-1:0] RECIP    = MUL_B_W'((64'd1 << RECIP_SHIFT) / SLOT_DIV_L);
    localparam int               Q_W        = PROD_W - RECIP_SHIFT;

    typedef struct packed {
        logic mul_en;
        logic fold_en;
        logic fold_two;
    } t_alu_ctl;

endpackage

`default_nettype wire

### rtl/sdlr_alu.sv
`default_nettype none

module sdlr_alu (
    input  wire logic                         i_clk,
    input  wire sdlr_pkg::t_alu_ctl           i_ctl,
    input  wire logic [sdlr_pkg::VAL_W-1:0]   i_a,
    input  wire logic [sdlr_pkg::MUL_B_W-1:0] i_b,
    output logic      [sdlr_pkg::PROD_W-1:0]  o_prod,
    output logic      [sdlr_pkg::VAL_W-1:0]   o_red
);

    logic [sdlr_pkg::PROD_W-1:0]    r_prod;
    logic [sdlr_pkg::VAL_W:0]       r_fold;
    logic                           r_fold_two;
    logic [sdlr_pkg::GEN_MUL_W-1:0] w_hi;
    logic [sdlr_pkg::FOLD_W-1:0]    w_fold_k;
    logic [sdlr_pkg::VAL_W:0]       n_fold;
    logic [sdlr_pkg::VAL_W:0]       w_mod;

    // Generator products stay below 2^47, so the high part is 16 bits.
    assign w_hi     = r_prod[sdlr_pkg::VAL_W +: sdlr_pkg::GEN_MUL_W];
    assign w_fold_k = i_ctl.fold_two ? sdlr_pkg::FOLD_TWO : sdlr_pkg::FOLD_ONE;
    assign n_fold   = (sdlr_pkg::VAL_W+1)'(w_hi) * (sdlr_pkg::VAL_W+1)'(w_fold_k)
                    + (sdlr_pkg::VAL_W+1)'(r_prod[sdlr_pkg::VAL_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= sdlr_pkg::PROD_W'(i_a) * sdlr_pkg::PROD_W'(i_b);
        end
        if (i_ctl.fold_en) begin
            r_fold     <= n_fold;
            r_fold_two <= i_ctl.fold_two;
        end
    end

    // The folded sum is below twice the modulus, so one subtraction finishes it.
    assign w_mod  = {1'b0, (r_fold_two ? sdlr_pkg::MOD_TWO : sdlr_pkg::MOD_ONE)};
    assign o_red  = (r_fold >= w_mod) ? sdlr_pkg::VAL_W'(r_fold - w_mod)
                                      : r_fold[sdlr_pkg::VAL_W-1:0];
    assign o_prod = r_prod;

endmodule

`default_nettype wire

### rtl/shuffled_dual_lcg_random_unit.sv
`default_nettype none

// Channel   Direction  Item fields (tdata from bit 0 up; tuser)
// s_axis    in         tdata: seed[30:0], zero pad; tuser: action
// m_axis    out        tdata: value[30:0], zero pad
//
// A draw passes S_MUL1, S_FOLD1, S_RED1, S_RED2, S_SLOT and S_OUT to the result
// register (both generators and the slot quotient share one multiply/fold/reduce
// unit, then one table read and one table write); no item is taken until S_IDLE.
// A reseed first runs TABLE_DEPTH+8 warm-up steps of S_WMUL, S_WFOLD and S_WRED.
// Reset is synchronous; the shuffle table is valid only after a reseed. A waiting
// result does not block input; it stalls only the final step of the next item.
module shuffled_dual_lcg_random_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,   // seed[30:0], pad
    input  wire logic        i_s_axis_tuser,   // action
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic      [31:0] o_m_axis_tdata    // value[30:0], pad
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_WMUL,
        S_WFOLD,
        S_WRED,
        S_MUL1,
        S_FOLD1,
        S_RED1,
        S_RED2,
        S_SLOT,
        S_OUT
    } t_state;

    t_state                          r_state;
    logic [sdlr_pkg::VAL_W-1:0]      r_gen_one;
    logic [sdlr_pkg::VAL_W-1:0]      r_gen_two;
    logic [sdlr_pkg::VAL_W-1:0]      r_last;
    logic [sdlr_pkg::CNT_W-1:0]      r_cnt;
    logic [sdlr_pkg::Q_W-1:0]        r_q;
    logic [sdlr_pkg::IDX_W-1:0]      r_slot;
    logic [sdlr_pkg::VAL_W-1:0]      r_rd;
    logic                            r_out_valid;
    logic [sdlr_pkg::VAL_W-1:0]      r_out_data;
    logic [sdlr_pkg::VAL_W-1:0]      r_table [sdlr_pkg::TABLE_DEPTH];

    sdlr_pkg::t_alu_ctl              w_ctl;
    logic [sdlr_pkg::VAL_W-1:0]      w_a;
    logic [sdlr_pkg::MUL_B_W-1:0]    w_b;
    logic [sdlr_pkg::PROD_W-1:0]     w_prod;
    logic [sdlr_pkg::VAL_W-1:0]      w_red;
    logic                            w_accept;
    logic                            w_out_free;
    logic                            w_out_load;
    logic [sdlr_pkg::VAL_W-1:0]      w_seed;
    logic [sdlr_pkg::Q_W-1:0]        w_q_est;
    logic [sdlr_pkg::Q_W-1:0]        w_q_fin;
    logic [sdlr_pkg::IDX_W-1:0]      w_slot;
    logic signed [sdlr_pkg::VAL_W:0] w_diff;
    logic [sdlr_pkg::VAL_W:0]        w_wrap;
    logic [sdlr_pkg::VAL_W-1:0]      w_value;
    logic                            w_wr_en;
    logic [sdlr_pkg::IDX_W-1:0]      w_wr_addr;
    logic [sdlr_pkg::VAL_W-1:0]      w_wr_data;

    sdlr_alu u_alu (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_a    (w_a),
        .i_b    (w_b),
        .o_prod (w_prod),
        .o_red  (w_red)
    );

    assign w_accept   = i_s_axis_tvalid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || i_m_axis_tready;
    assign w_out_load = (r_state == S_OUT) && w_out_free;
    assign w_seed     = (i_s_axis_tdata[sdlr_pkg::VAL_W-1:0] == '0) ? sdlr_pkg::VAL_W'(1)
                                                                   : i_s_axis_tdata[sdlr_pkg::VAL_W-1:0];

    assign w_q_est = w_prod[sdlr_pkg::PROD_W-1:sdlr_pkg::RECIP_SHIFT];

    // In S_SLOT the product holds (estimate + 1) * SLOT_DIV.
    always_comb begin
        w_q_fin = r_q;
        if ({1'b0, r_last} >= w_prod[sdlr_pkg::VAL_W:0]) begin
            w_q_fin = sdlr_pkg::Q_W'(r_q + 1'b1);
        end
        if (w_q_fin >= sdlr_pkg::Q_W'(sdlr_pkg::TABLE_DEPTH)) begin
            w_slot = sdlr_pkg::IDX_W'(sdlr_pkg::TABLE_DEPTH - 1);
        end else begin
            w_slot = w_q_fin[sdlr_pkg::IDX_W-1:0];
        end
    end

    assign w_diff  = $signed({1'b0, r_rd}) - $signed({1'b0, r_gen_two});
    assign w_wrap  = (w_diff[sdlr_pkg::VAL_W] || (w_diff == '0))
                   ? $unsigned(w_diff) + {1'b0, sdlr_pkg::TOP_VAL}
                   : $unsigned(w_diff);
    assign w_value = w_wrap[sdlr_pkg::VAL_W-1:0];

    always_comb begin
        w_ctl = '0;
        w_a   = r_gen_one;
        w_b   = sdlr_pkg::MUL_B_W'(sdlr_pkg::MUL_ONE);
        case (r_state)
            S_WMUL, S_MUL1: begin
                w_ctl.mul_en = 1'b1;
            end
            S_WFOLD: begin
                w_ctl.fold_en = 1'b1;
            end
            S_FOLD1: begin
                w_ctl.fold_en = 1'b1;
                w_ctl.mul_en  = 1'b1;
                w_a           = r_gen_two;
                w_b           = sdlr_pkg::MUL_B_W'(sdlr_pkg::MUL_TWO);
            end
            S_RED1: begin
                w_ctl.fold_en  = 1'b1;
                w_ctl.fold_two = 1'b1;
                w_ctl.mul_en   = 1'b1;
                w_a            = r_last;
                w_b            = sdlr_pkg::RECIP;
            end
            S_RED2: begin
                w_ctl.mul_en = 1'b1;
                w_a          = sdlr_pkg::SLOT_DIV;
                w_b          = sdlr_pkg::MUL_B_W'(sdlr_pkg::Q_W'(w_q_est + 1'b1));
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_slot;
        w_wr_data = r_gen_one;
        if (r_state == S_WRED) begin
            w_wr_en   = (r_cnt < sdlr_pkg::CNT_W'(sdlr_pkg::TABLE_DEPTH));
            w_wr_addr = r_cnt[sdlr_pkg::IDX_W-1:0];
            w_wr_data = w_red;
        end else if (r_state == S_OUT) begin
            w_wr_en = w_out_free;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_table[w_wr_addr] <= w_wr_data;
        end
        if (r_state == S_SLOT) begin
            r_rd <= r_table[w_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_gen_one   <= sdlr_pkg::VAL_W'(1);
            r_gen_two   <= sdlr_pkg::GEN_TWO_INIT;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_s_axis_tuser) begin
                            r_gen_one <= w_seed;
                            r_gen_two <= w_seed;
                            r_cnt     <= sdlr_pkg::CNT_W'(sdlr_pkg::WARM_STEPS - 1);
                            r_state   <= S_WMUL;
                        end else begin
                            r_state <= S_MUL1;
                        end
                    end
                end
                S_WMUL: begin
                    r_state <= S_WFOLD;
                end
                S_WFOLD: begin
                    r_state <= S_WRED;
                end
                S_WRED: begin
                    r_gen_one <= w_red;
                    if (r_cnt == '0) begin
                        // The last warm-up value is slot 0 and seeds the first pick.
                        r_last  <= w_red;
                        r_state <= S_MUL1;
                    end else begin
                        r_cnt   <= r_cnt - 1'b1;
                        r_state <= S_WMUL;
                    end
                end
                S_MUL1: begin
                    r_state <= S_FOLD1;
                end
                S_FOLD1: begin
                    r_state <= S_RED1;
                end
                S_RED1: begin
                    r_gen_one <= w_red;
                    r_state   <= S_RED2;
                end
                S_RED2: begin
                    r_gen_two <= w_red;
                    r_q       <= w_q_est;
                    r_state   <= S_SLOT;
                end
                S_SLOT: begin
                    r_slot  <= w_slot;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_last     <= w_value;
                        r_out_data <= w_value;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_data};

endmodule

`default_nettype wire
